@@ sv/chbd_pkg.sv @@
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; imported by every module of the block.
package chbd_pkg;

    // Byte codes seen on the wire
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_SEMI = 8'd59;

    // Most hex digits on one chunk-size line
    localparam logic [4:0] MAX_DIGITS = 5'd16;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_CHUNK        = 2'd0;
    localparam logic [1:0] REG_MAX_BODY         = 2'd1;
    localparam logic [1:0] REG_MAX_SIZE_LINE    = 2'd2;
    localparam logic [1:0] REG_MAX_TRAILER_LINE = 2'd3;

    // Configuration reset values
    localparam logic [31:0] RST_MAX_CHUNK        = 32'd16777216;
    localparam logic [47:0] RST_MAX_BODY         = 48'd67108864;
    localparam logic [15:0] RST_MAX_SIZE_LINE    = 16'd4096;
    localparam logic [15:0] RST_MAX_TRAILER_LINE = 16'd8192;

    typedef enum logic [1:0] {
        MODE_DATA    = 2'd0,
        MODE_EOS     = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        PH_FIRST      = 4'd0,
        PH_DIGITS     = 4'd1,
        PH_EXT        = 4'd2,
        PH_SIZE_LF    = 4'd3,
        PH_DATA       = 4'd4,
        PH_DATA_CR    = 4'd5,
        PH_DATA_LF    = 4'd6,
        PH_TRAILER    = 4'd7,
        PH_TRAILER_LF = 4'd8,
        PH_DONE       = 4'd9,
        PH_ERROR      = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        K_BODY     = 3'd0,
        K_TRAILER  = 3'd1,
        K_LINE_END = 3'd2,
        K_DONE     = 3'd3,
        K_ERROR    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_LIMIT     = 2'd2,
        ERR_EOS_DATA  = 2'd3
    } err_t;

    // Limit registers as seen by the parser
    typedef struct packed {
        logic [31:0] max_chunk;
        logic [47:0] max_body;
        logic [15:0] max_size_line;
        logic [15:0] max_trailer_line;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        kind_t      kind;
        err_t       error_code;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // ASCII hex digit decode, either case
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'd48);
        end
        else if (c >= 8'd97 && c <= 8'd102) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'd87);
        end
        else if (c >= 8'd65 && c <= 8'd70) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'd55);
        end
        return h;
    endfunction

endpackage

@@ sv/chbd_cfg.sv @@
// Limit registers of the chunked body decoder, written over the config channel.
// Depends on chbd_pkg.
module chbd_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    output chbd_pkg::cfg_t      cfg
);
    import chbd_pkg::*;

    cfg_t cfg_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_chunk        <= RST_MAX_CHUNK;
            cfg_reg.max_body         <= RST_MAX_BODY;
            cfg_reg.max_size_line    <= RST_MAX_SIZE_LINE;
            cfg_reg.max_trailer_line <= RST_MAX_TRAILER_LINE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_CHUNK:        cfg_reg.max_chunk        <= cfg_data[31:0];
                REG_MAX_BODY:         cfg_reg.max_body         <= cfg_data;
                REG_MAX_SIZE_LINE:    cfg_reg.max_size_line    <= cfg_data[15:0];
                REG_MAX_TRAILER_LINE: cfg_reg.max_trailer_line <= cfg_data[15:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

@@ sv/chbd_parser.sv @@
// Chunked-encoding parser: phase machine, size accumulator, counters and
// the result of one byte per step. Depends on chbd_pkg.
module chbd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [1:0]          mode,
    input  logic [7:0]          in_byte,
    input  chbd_pkg::cfg_t      cfg,
    output chbd_pkg::res_t      res
);
    import chbd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [63:0] chunk_rem_reg, chunk_rem_next;
    logic [4:0]  digit_cnt_reg, digit_cnt_next;
    logic [63:0] body_total_reg, body_total_next;
    logic [15:0] line_len_reg, line_len_next;
    logic [63:0] sum_reg, sum_next;

    hex_t        hx;
    logic [64:0] sum_wide;
    logic        size_line_full;
    logic        trailer_line_full;
    logic        chunk_over;
    logic        body_over;
    logic        eos_in_data;

    // Saturating body total plus current size; registered every cycle. The
    // CR that enters PH_SIZE_LF leaves both operands unchanged, so the value
    // is current when the LF arrives.
    assign sum_wide = {1'b0, body_total_reg} + {1'b0, chunk_rem_reg};
    assign sum_next = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // Per-byte checks
    assign hx                = hex_decode(in_byte);
    assign size_line_full    = (line_len_reg >= cfg.max_size_line);
    assign trailer_line_full = (line_len_reg >= cfg.max_trailer_line);
    assign chunk_over        = (chunk_rem_reg[63:32] != 32'd0) ||
                               (chunk_rem_reg[31:0] > cfg.max_chunk);
    assign body_over         = (sum_reg[63:48] != 16'd0) ||
                               (sum_reg[47:0] > cfg.max_body);
    assign eos_in_data       = (phase_reg == PH_DATA) || (phase_reg == PH_DATA_CR) ||
                               (phase_reg == PH_DATA_LF);

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        chunk_rem_next  = chunk_rem_reg;
        digit_cnt_next  = digit_cnt_reg;
        body_total_next = body_total_reg;
        line_len_next   = line_len_reg;
        if (step)
        begin
            if (mode == MODE_RESTART)
            begin
                phase_next      = PH_FIRST;
                chunk_rem_next  = 64'd0;
                digit_cnt_next  = 5'd0;
                body_total_next = 64'd0;
                line_len_next   = 16'd0;
            end
            else if ((mode == MODE_EOS) && (phase_reg != PH_DONE) &&
                     (phase_reg != PH_ERROR))
            begin
                phase_next = PH_ERROR;
            end
            else if ((mode == MODE_DATA) && (phase_reg != PH_DONE) &&
                     (phase_reg != PH_ERROR))
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if (size_line_full || !hx.ok)
                            phase_next = PH_ERROR;
                        else
                        begin
                            line_len_next  = line_len_reg + 16'd1;
                            chunk_rem_next = {60'd0, hx.val};
                            digit_cnt_next = 5'd1;
                            phase_next     = PH_DIGITS;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (in_byte == CH_CR)
                            phase_next = PH_SIZE_LF;
                        else if (size_line_full)
                            phase_next = PH_ERROR;
                        else
                        begin
                            line_len_next = line_len_reg + 16'd1;
                            if (hx.ok)
                            begin
                                if (digit_cnt_reg >= MAX_DIGITS)
                                    phase_next = PH_ERROR;
                                else
                                begin
                                    chunk_rem_next = {chunk_rem_reg[59:0], hx.val};
                                    digit_cnt_next = digit_cnt_reg + 5'd1;
                                end
                            end
                            else if (in_byte != CH_SEMI)
                                phase_next = PH_ERROR;
                            else
                                phase_next = PH_EXT;
                        end
                    end
                    PH_EXT:
                    begin
                        if (in_byte == CH_CR)
                            phase_next = PH_SIZE_LF;
                        else if (size_line_full)
                            phase_next = PH_ERROR;
                        else
                            line_len_next = line_len_reg + 16'd1;
                    end
                    PH_SIZE_LF:
                    begin
                        if ((in_byte != CH_LF) || chunk_over)
                            phase_next = PH_ERROR;
                        else
                        begin
                            line_len_next  = 16'd0;
                            digit_cnt_next = 5'd0;
                            if (chunk_rem_reg == 64'd0)
                                phase_next = PH_TRAILER;
                            else
                            begin
                                body_total_next = sum_reg;
                                phase_next      = body_over ? PH_ERROR : PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        chunk_rem_next = chunk_rem_reg - 64'd1;
                        if (chunk_rem_reg == 64'd1)
                            phase_next = PH_DATA_CR;
                    end
                    PH_DATA_CR:
                    begin
                        phase_next = (in_byte == CH_CR) ? PH_DATA_LF : PH_ERROR;
                    end
                    PH_DATA_LF:
                    begin
                        if (in_byte != CH_LF)
                            phase_next = PH_ERROR;
                        else
                        begin
                            line_len_next = 16'd0;
                            phase_next    = PH_FIRST;
                        end
                    end
                    PH_TRAILER:
                    begin
                        if (in_byte == CH_CR)
                            phase_next = PH_TRAILER_LF;
                        else if (trailer_line_full)
                            phase_next = PH_ERROR;
                        else
                            line_len_next = line_len_reg + 16'd1;
                    end
                    PH_TRAILER_LF:
                    begin
                        if (in_byte != CH_LF)
                            phase_next = PH_ERROR;
                        else if (line_len_reg == 16'd0)
                            phase_next = PH_DONE;
                        else
                        begin
                            line_len_next = 16'd0;
                            phase_next    = PH_TRAILER;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Result of this step
    always_comb
    begin
        res = '{valid: 1'b0, out_byte: 8'd0, kind: K_BODY, error_code: ERR_NONE};
        if (step && (mode != MODE_RESTART) && (phase_reg != PH_DONE) &&
            (phase_reg != PH_ERROR))
        begin
            if (mode == MODE_EOS)
            begin
                res.valid      = 1'b1;
                res.kind       = K_ERROR;
                res.error_code = eos_in_data ? ERR_EOS_DATA : ERR_MALFORMED;
            end
            else if (mode == MODE_DATA)
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if (size_line_full || !hx.ok)
                        begin
                            res.valid      = 1'b1;
                            res.kind       = K_ERROR;
                            res.error_code = size_line_full ? ERR_LIMIT : ERR_MALFORMED;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (in_byte != CH_CR)
                        begin
                            if (size_line_full || (hx.ok && (digit_cnt_reg >= MAX_DIGITS)))
                            begin
                                res.valid      = 1'b1;
                                res.kind       = K_ERROR;
                                res.error_code = ERR_LIMIT;
                            end
                            else if (!hx.ok && (in_byte != CH_SEMI))
                            begin
                                res.valid      = 1'b1;
                                res.kind       = K_ERROR;
                                res.error_code = ERR_MALFORMED;
                            end
                        end
                    end
                    PH_EXT:
                    begin
                        if ((in_byte != CH_CR) && size_line_full)
                        begin
                            res.valid      = 1'b1;
                            res.kind       = K_ERROR;
                            res.error_code = ERR_LIMIT;
                        end
                    end
                    PH_SIZE_LF:
                    begin
                        if (in_byte != CH_LF)
                        begin
                            res.valid      = 1'b1;
                            res.kind       = K_ERROR;
                            res.error_code = ERR_MALFORMED;
                        end
                        else if (chunk_over ||
                                 ((chunk_rem_reg != 64'd0) && body_over))
                        begin
                            res.valid      = 1'b1;
                            res.kind       = K_ERROR;
                            res.error_code = ERR_LIMIT;
                        end
                    end
                    PH_DATA:
                    begin
                        res.valid    = 1'b1;
                        res.out_byte = in_byte;
                        res.kind     = K_BODY;
                    end
                    PH_DATA_CR:
                    begin
                        if (in_byte != CH_CR)
                        begin
                            res.valid      = 1'b1;
                            res.kind       = K_ERROR;
                            res.error_code = ERR_MALFORMED;
                        end
                    end
                    PH_DATA_LF:
                    begin
                        if (in_byte != CH_LF)
                        begin
                            res.valid      = 1'b1;
                            res.kind       = K_ERROR;
                            res.error_code = ERR_MALFORMED;
                        end
                    end
                    PH_TRAILER:
                    begin
                        if (in_byte != CH_CR)
                        begin
                            res.valid = 1'b1;
                            if (trailer_line_full)
                            begin
                                res.kind       = K_ERROR;
                                res.error_code = ERR_LIMIT;
                            end
                            else
                            begin
                                res.out_byte = in_byte;
                                res.kind     = K_TRAILER;
                            end
                        end
                    end
                    PH_TRAILER_LF:
                    begin
                        res.valid = 1'b1;
                        if (in_byte != CH_LF)
                        begin
                            res.kind       = K_ERROR;
                            res.error_code = ERR_MALFORMED;
                        end
                        else
                            res.kind = (line_len_reg == 16'd0) ? K_DONE : K_LINE_END;
                    end
                    default:
                    begin
                        res.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            chunk_rem_reg  <= 64'd0;
            digit_cnt_reg  <= 5'd0;
            body_total_reg <= 64'd0;
            line_len_reg   <= 16'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            chunk_rem_reg  <= chunk_rem_next;
            digit_cnt_reg  <= digit_cnt_next;
            body_total_reg <= body_total_next;
            line_len_reg   <= line_len_next;
        end
    end

    // An error result always parks the machine in the error phase
    a_err_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.kind == K_ERROR)) |=> (phase_reg == PH_ERROR))
        else $error("error result without error phase");

    // A chunk in its data phase always has bytes left
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (chunk_rem_reg != 64'd0))
        else $error("data phase with empty chunk");

    // Digit count never passes the limit
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_cnt_reg <= MAX_DIGITS)
        else $error("digit count overflow");

    // Done result only from the end of a blank trailer line
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.kind == K_DONE)) |-> (phase_reg == PH_TRAILER_LF))
        else $error("done result from wrong phase");

endmodule

@@ sv/http_chunked_body_decoder.sv @@
// A result reaches m_* through the input register, the parser step and the
// output register after its input transaction is accepted.
// Throughput: one byte per cycle; s_tready drops only while the input register
// holds a byte and a waiting result has m_tready low.
// Reset (rst_n low, asynchronous): parser to first size digit, counters to
// zero, limit registers to defaults, both stages empty. No clearing pass.
module http_chunked_body_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [4:0]  m_tuser,   // [2:0] kind, [4:3] error_code
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import chbd_pkg::*;

    cfg_t       cfg;
    res_t       res;
    logic       in_valid_reg;
    logic [1:0] in_mode_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [4:0] out_user_reg;
    logic       advance;

    // Pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    chbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    chbd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .mode    (in_mode_reg),
        .in_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res.valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_byte_reg <= res.out_byte;
            out_user_reg <= {res.error_code, res.kind};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_user_reg;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result overwritten");

    // The parser steps only on a held input transaction
    a_step_held: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> in_valid_reg)
        else $error("step without input");

    // A result taken with no new one leaves the output empty
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && m_tready && !(advance && res.valid)) |=> !out_valid_reg)
        else $error("output did not drain");

endmodule

@@ tb/http_chunked_body_decoder_tb.sv @@
// Self-checking testbench for http_chunked_body_decoder: directed and random chunked
// bodies under several limit settings, checked against an in-bench decoder model.
// Depends on chbd_pkg and the http_chunked_body_decoder RTL.
module http_chunked_body_decoder_tb;
    import chbd_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         IDLE_PCT      = 7;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         STALL_LIMIT   = 500;

    typedef struct {
        logic [7:0] b;
        kind_t      k;
        err_t       e;
    } decode_event_t;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] b;
    } stream_item_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic [1:0]  s_tuser   = 2'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [4:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [47:0] cfg_data  = 48'd0;

    http_chunked_body_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] in_byte
        .s_tuser   (s_tuser),   // [1:0] mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] out_byte
        .m_tuser   (m_tuser),   // [2:0] kind, [4:3] error_code
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Limit registers as the model sees them
    logic [31:0] lim_chunk        = RST_MAX_CHUNK;
    logic [47:0] lim_body         = RST_MAX_BODY;
    logic [15:0] lim_size_line    = RST_MAX_SIZE_LINE;
    logic [15:0] lim_trailer_line = RST_MAX_TRAILER_LINE;

    // Parser state of the model
    phase_t      ph         = PH_FIRST;
    logic [63:0] chunk_left = 64'd0;
    int          digits     = 0;
    logic [63:0] body_total = 64'd0;
    logic [15:0] line_len   = 16'd0;

    decode_event_t decoded_q[$];
    stream_item_t  message_q[$];
    int            mismatch_count = 0;
    int            stall_cycles   = 0;
    bit            no_idle        = 1'b0;

    // ---------------------------------------------------------------------
    // Decoder model
    // ---------------------------------------------------------------------
    function automatic void clear_parser();
        ph         = PH_FIRST;
        chunk_left = 64'd0;
        digits     = 0;
        body_total = 64'd0;
        line_len   = 16'd0;
    endfunction

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") v = 4'(c - "0");
        else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
        else return 1'b0;
        return 1'b1;
    endfunction

    // Counts one content byte of a line; 0 once the line has reached its limit
    function automatic bit take_line_byte(input logic [15:0] limit);
        if (line_len >= limit) return 1'b0;
        line_len = line_len + 16'd1;
        return 1'b1;
    endfunction

    function automatic bit raise_error(input err_t code, output decode_event_t ev);
        ph = PH_ERROR;
        ev = '{8'd0, K_ERROR, code};
        return 1'b1;
    endfunction

    // One input transaction; returns 1 when it produces a result
    function automatic bit chunked_step(input logic [1:0] mode, input logic [7:0] c,
                                        output decode_event_t ev);
        logic [3:0] nib;
        bit         is_hex;
        ev     = '{8'd0, K_BODY, ERR_NONE};
        is_hex = hex_nibble(c, nib);
        if (mode == MODE_RESTART) begin
            clear_parser();
            return 1'b0;
        end
        if (mode == MODE_UNUSED || ph == PH_DONE || ph == PH_ERROR)
            return 1'b0;
        if (mode == MODE_EOS) begin
            if (ph == PH_DATA || ph == PH_DATA_CR || ph == PH_DATA_LF)
                return raise_error(ERR_EOS_DATA, ev);
            return raise_error(ERR_MALFORMED, ev);
        end
        case (ph)
            PH_FIRST:
            begin
                if (!take_line_byte(lim_size_line)) return raise_error(ERR_LIMIT, ev);
                if (!is_hex) return raise_error(ERR_MALFORMED, ev);
                chunk_left = 64'(nib);
                digits     = 1;
                ph         = PH_DIGITS;
            end
            PH_DIGITS:
            begin
                if (c == CH_CR) begin
                    ph = PH_SIZE_LF;
                    return 1'b0;
                end
                if (!take_line_byte(lim_size_line)) return raise_error(ERR_LIMIT, ev);
                if (is_hex) begin
                    if (digits >= int'(MAX_DIGITS)) return raise_error(ERR_LIMIT, ev);
                    chunk_left = {chunk_left[59:0], nib};
                    digits++;
                end
                else if (c != CH_SEMI) return raise_error(ERR_MALFORMED, ev);
                else ph = PH_EXT;
            end
            PH_EXT:
            begin
                if (c == CH_CR) ph = PH_SIZE_LF;
                else if (!take_line_byte(lim_size_line)) return raise_error(ERR_LIMIT, ev);
            end
            PH_SIZE_LF:
            begin
                if (c != CH_LF) return raise_error(ERR_MALFORMED, ev);
                if (chunk_left > 64'(lim_chunk)) return raise_error(ERR_LIMIT, ev);
                line_len = 16'd0;
                digits   = 0;
                if (chunk_left == 64'd0) begin
                    ph = PH_TRAILER;
                    return 1'b0;
                end
                // running total saturates at all ones
                if (body_total > ~64'd0 - chunk_left) body_total = ~64'd0;
                else body_total = body_total + chunk_left;
                if (body_total > 64'(lim_body)) return raise_error(ERR_LIMIT, ev);
                ph = PH_DATA;
            end
            PH_DATA:
            begin
                chunk_left = chunk_left - 64'd1;
                if (chunk_left == 64'd0) ph = PH_DATA_CR;
                ev = '{c, K_BODY, ERR_NONE};
                return 1'b1;
            end
            PH_DATA_CR:
            begin
                if (c != CH_CR) return raise_error(ERR_MALFORMED, ev);
                ph = PH_DATA_LF;
            end
            PH_DATA_LF:
            begin
                if (c != CH_LF) return raise_error(ERR_MALFORMED, ev);
                line_len = 16'd0;
                ph       = PH_FIRST;
            end
            PH_TRAILER:
            begin
                if (c == CH_CR) begin
                    ph = PH_TRAILER_LF;
                    return 1'b0;
                end
                if (!take_line_byte(lim_trailer_line)) return raise_error(ERR_LIMIT, ev);
                ev = '{c, K_TRAILER, ERR_NONE};
                return 1'b1;
            end
            PH_TRAILER_LF:
            begin
                if (c != CH_LF) return raise_error(ERR_MALFORMED, ev);
                if (line_len == 16'd0) begin
                    ph = PH_DONE;
                    ev = '{8'd0, K_DONE, ERR_NONE};
                end
                else begin
                    line_len = 16'd0;
                    ph       = PH_TRAILER;
                    ev       = '{8'd0, K_LINE_END, ERR_NONE};
                end
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    // Sends one input transaction, with random idle cycles ahead of it unless no_idle is set
    task automatic send_item(input logic [1:0] mode, input logic [7:0] c);
        decode_event_t ev;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        if (chunked_step(mode, c, ev)) decoded_q.push_back(ev);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(MODE_DATA, s[i]);
    endtask

    // Holds the sender until every predicted result has come, then lets the
    // pipeline empty out behind items that gave no result
    task automatic settle();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MAX_CHUNK:        lim_chunk        = value[31:0];
            REG_MAX_BODY:         lim_body         = value;
            REG_MAX_SIZE_LINE:    lim_size_line    = value[15:0];
            REG_MAX_TRAILER_LINE: lim_trailer_line = value[15:0];
            default:              ;
        endcase
    endtask

    task automatic set_limits(input logic [31:0] chunk, input logic [47:0] body,
                              input logic [15:0] size_line, input logic [15:0] trailer_line);
        settle();
        write_reg(REG_MAX_CHUNK, 48'(chunk));
        write_reg(REG_MAX_BODY, body);
        write_reg(REG_MAX_SIZE_LINE, 48'(size_line));
        write_reg(REG_MAX_TRAILER_LINE, 48'(trailer_line));
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_item(input logic [1:0] mode, input logic [7:0] b);
        message_q.push_back('{mode, b});
    endfunction

    // Extension or trailer content: anything but CR
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == CH_CR) ? CH_SEMI : b;
    endfunction

    // Size line: width hex digits of val in mixed case, optional extension, CR LF
    function automatic void add_size_line(input logic [63:0] val, input int width);
        logic [3:0] nib;
        for (int k = width - 1; k >= 0; k--) begin
            nib = 4'(val >> (4 * k));
            if (nib < 4'd10) add_item(MODE_DATA, "0" + nib);
            else add_item(MODE_DATA,
                          8'(($urandom_range(0, 1) ? "A" : "a") + nib - 8'd10));
        end
        if ($urandom_range(0, 3) == 0) begin
            add_item(MODE_DATA, CH_SEMI);
            repeat ($urandom_range(0, 4)) add_item(MODE_DATA, text_byte());
        end
        add_item(MODE_DATA, CH_CR);
        add_item(MODE_DATA, CH_LF);
    endfunction

    // Mostly well-formed message with random content, some of it broken
    function automatic void build_message();
        int          r;
        int          w;
        int          n;
        int          pos;
        logic [63:0] val;
        message_q.delete();
        add_item(MODE_RESTART, 8'($urandom));
        repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 99);
            if (r < 75) val = 64'($urandom_range(1, 6));
            else if (r < 88) val = 64'($urandom_range(7, 40));
            else val = {$urandom, $urandom} >> $urandom_range(0, 63);
            if (val == 64'd0) val = 64'd1;
            w = 1;
            while (w < 16 && (val >> (4 * w)) != 64'd0) w++;
            r = $urandom_range(0, 99);
            if (r < 8) w = 17;
            else if (r < 20) w = $urandom_range(w, 16);
            add_size_line(val, w);
            // large chunks are cut short by an end of stream
            n = (val > 64'd40) ? $urandom_range(0, 3) : int'(val);
            repeat (n) add_item(MODE_DATA, 8'($urandom));
            if (val > 64'd40) add_item(MODE_EOS, 8'($urandom));
            add_item(MODE_DATA, CH_CR);
            add_item(MODE_DATA, CH_LF);
        end
        add_size_line(64'd0, $urandom_range(1, 3));
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 6)) add_item(MODE_DATA, text_byte());
            add_item(MODE_DATA, CH_CR);
            add_item(MODE_DATA, CH_LF);
        end
        add_item(MODE_DATA, CH_CR);
        add_item(MODE_DATA, CH_LF);

        // damage: overwrite, early end of stream, truncation, unused mode
        r   = $urandom_range(0, 99);
        pos = $urandom_range(1, message_q.size() - 1);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0:       message_q[pos].b = CH_CR;
                1:       message_q[pos].b = CH_LF;
                2:       message_q[pos].b = CH_SEMI;
                default: message_q[pos].b = 8'($urandom);
            endcase
        end
        else if (r < 20) message_q.insert(pos, '{MODE_EOS, 8'($urandom)});
        else if (r < 28) begin
            while (message_q.size() > pos) void'(message_q.pop_back());
            add_item(MODE_EOS, 8'($urandom));
        end
        else if (r < 34) message_q.insert(pos, '{MODE_UNUSED, 8'($urandom)});
        if ($urandom_range(0, 4) == 0) begin
            add_item(MODE_DATA, 8'($urandom));
            add_item(MODE_EOS, 8'($urandom));
        end
    endfunction

    task automatic run_random_messages(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            build_message();
            foreach (message_q[i]) begin
                sent++;
                send_item(message_q[i].mode, message_q[i].b);
            end
            if ($urandom_range(0, 19) == 0) settle();
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // Full message: two extreme body bytes, one trailer line, then ignored input
    task automatic test_wellformed_message();
        send_item(MODE_RESTART, 8'hFF);
        send_text("2\015\012");
        send_item(MODE_DATA, 8'h00);
        send_item(MODE_DATA, 8'hFF);
        send_text("\015\0120\015\012X\015\012\015\012");
        send_item(MODE_DATA, "z");
        send_item(MODE_EOS, 8'h00);
    endtask

    // End of stream on a size line and in chunk data, unused mode, bad first byte
    task automatic test_stream_faults();
        send_item(MODE_RESTART, 8'h00);
        send_item(MODE_DATA, "5");
        send_item(MODE_EOS, 8'h00);
        send_item(MODE_RESTART, 8'h00);
        send_text("1\015\012");
        send_item(MODE_EOS, 8'h00);
        send_item(MODE_RESTART, 8'h00);
        send_item(MODE_UNUSED, "1");
        send_item(MODE_DATA, "g");
    endtask

    task automatic test_tight_limits();
        set_limits(32'd4, 48'd10, 16'd3, 16'd2);
        run_random_messages(80);
    endtask

    task automatic test_minimum_limits();
        set_limits(32'd0, 48'd0, 16'd1, 16'd1);
        run_random_messages(50);
    endtask

    // Widest limits, with neither side idling
    task automatic test_maximum_limits();
        set_limits(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
        no_idle = 1'b1;
        run_random_messages(90);
        no_idle = 1'b0;
    endtask

    task automatic test_default_limits();
        set_limits(RST_MAX_CHUNK, RST_MAX_BODY, RST_MAX_SIZE_LINE, RST_MAX_TRAILER_LINE);
        run_random_messages(90);
    endtask

    // ---------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ---------------------------------------------------------------------
    always @(posedge clk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        decode_event_t ev;
        if (rst_n && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got byte %0h kind %0d code %0d",
                         $time, m_tdata, m_tuser[2:0], m_tuser[4:3]);
                mismatch_count++;
            end
            else begin
                ev = decoded_q.pop_front();
                if (m_tdata !== ev.b) begin
                    $display("%0t: out_byte expected %0h, got %0h", $time, ev.b, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[2:0] !== ev.k) begin
                    $display("%0t: kind expected %0d, got %0d", $time, ev.k, m_tuser[2:0]);
                    mismatch_count++;
                end
                if (m_tuser[4:3] !== ev.e) begin
                    $display("%0t: error_code expected %0d, got %0d", $time, ev.e,
                             m_tuser[4:3]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("http_chunked_body_decoder_tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_wellformed_message();
        test_stream_faults();
        test_tight_limits();
        test_minimum_limits();
        test_maximum_limits();
        test_default_limits();
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("http_chunked_body_decoder_tb: clean");
        else
            $display("http_chunked_body_decoder_tb: errors");
        $finish;
    end

endmodule
